// File: design/sro_pkg.sv
package sro_pkg;

   localparam int COORD_BITS = 32;
   localparam int SCALE_BITS = 11;
   localparam int SIZE_BITS  = 31;
   localparam int OUT_BITS   = 43;
   localparam int CSR_BITS   = (SIZE_BITS > SCALE_BITS) ? SIZE_BITS : SCALE_BITS;

   localparam int PROD_BITS  = COORD_BITS + SCALE_BITS;
   localparam int MULW_BITS  = SIZE_BITS + SCALE_BITS;
   localparam int HALF_BITS  = MULW_BITS - 1;
   localparam int SUM_BITS   = ((PROD_BITS > HALF_BITS + 1) ? PROD_BITS : HALF_BITS + 1) + 1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCALE_FACTOR    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_APERTURE_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_APERTURE_HEIGHT = 2'd2;

   localparam int STEP_BITS = 3;
   localparam int DIR_BITS  = 3;
   localparam int MAX_STEPS = 6;
   localparam int NUM_DIRS  = 8;

   // Direction classes of a move.
   localparam logic [DIR_BITS-1:0] DIR_XP_YP = 3'd0;
   localparam logic [DIR_BITS-1:0] DIR_XP_YN = 3'd1;
   localparam logic [DIR_BITS-1:0] DIR_XP_Y0 = 3'd2;
   localparam logic [DIR_BITS-1:0] DIR_XN_YP = 3'd3;
   localparam logic [DIR_BITS-1:0] DIR_XN_YN = 3'd4;
   localparam logic [DIR_BITS-1:0] DIR_XN_Y0 = 3'd5;
   localparam logic [DIR_BITS-1:0] DIR_X0_YP = 3'd6;
   localparam logic [DIR_BITS-1:0] DIR_X0_YN = 3'd7;

   // Vertex codes: which end point, and the sign of the width and height offsets.
   localparam int CODE_END_BIT   = 0;
   localparam int CODE_WPLUS_BIT = 1;
   localparam int CODE_HPLUS_BIT = 2;

   localparam logic [2:0] V_S_MM = 3'd0;
   localparam logic [2:0] V_E_MM = 3'd1;
   localparam logic [2:0] V_S_PM = 3'd2;
   localparam logic [2:0] V_E_PM = 3'd3;
   localparam logic [2:0] V_S_MP = 3'd4;
   localparam logic [2:0] V_E_MP = 3'd5;
   localparam logic [2:0] V_S_PP = 3'd6;
   localparam logic [2:0] V_E_PP = 3'd7;

   localparam logic [2:0] ORDER_TAB [NUM_DIRS][MAX_STEPS] = '{
      '{V_S_MM, V_S_PM, V_E_PM, V_E_PP, V_E_MP, V_S_MP},
      '{V_S_MM, V_E_MM, V_E_PM, V_E_PP, V_S_PP, V_S_MP},
      '{V_S_MM, V_E_PM, V_E_PP, V_S_MP, V_S_MM, V_S_MM},
      '{V_E_MM, V_S_MM, V_S_PM, V_S_PP, V_E_PP, V_E_MP},
      '{V_E_MM, V_E_PM, V_S_PM, V_S_PP, V_S_MP, V_E_MP},
      '{V_E_MM, V_S_PM, V_S_PP, V_E_MP, V_S_MM, V_S_MM},
      '{V_S_MM, V_S_PM, V_E_PP, V_E_MP, V_S_MM, V_S_MM},
      '{V_E_MM, V_E_PM, V_S_PP, V_S_MP, V_S_MM, V_S_MM}
   };

   localparam logic [STEP_BITS-1:0] ORDER_LAST [NUM_DIRS] = '{
      3'd5, 3'd5, 3'd3, 3'd5, 3'd5, 3'd3, 3'd3, 3'd3
   };

   typedef struct packed {
      logic signed [PROD_BITS-1:0] sx;
      logic signed [PROD_BITS-1:0] sy;
      logic signed [PROD_BITS-1:0] ex;
      logic signed [PROD_BITS-1:0] ey;
      logic [HALF_BITS-1:0]        w2;
      logic [HALF_BITS-1:0]        h2;
      logic [DIR_BITS-1:0]         dir;
   } sro_seg_type;

   typedef struct packed {
      logic                 empty;
      logic [QCNT_BITS-1:0] level;
   } sro_qstat_type;

   localparam logic signed [SUM_BITS-1:0] SAT_HI =
      {{(SUM_BITS - OUT_BITS + 1){1'b0}}, {(OUT_BITS - 1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] SAT_LO = ~SAT_HI;

   function automatic logic signed [OUT_BITS-1:0] sro_sat(input logic signed [SUM_BITS-1:0] v);
      logic signed [SUM_BITS-1:0] r;
      r = v;
      if (v > SAT_HI) begin
         r = SAT_HI;
      end else if (v < SAT_LO) begin
         r = SAT_LO;
      end
      return r[OUT_BITS-1:0];
   endfunction

endpackage

// File: design/sro_front.sv
module sro_front (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_wen,
   input  logic [sro_pkg::CSR_INDEX_BITS-1:0]        csr_index,
   input  logic [sro_pkg::CSR_BITS-1:0]              csr_wdata,
   input  logic                                      req_push,
   output logic                                      req_full,
   input  logic signed [sro_pkg::COORD_BITS-1:0]     req_start_x,
   input  logic signed [sro_pkg::COORD_BITS-1:0]     req_start_y,
   input  logic signed [sro_pkg::COORD_BITS-1:0]     req_end_x,
   input  logic signed [sro_pkg::COORD_BITS-1:0]     req_end_y,
   input  sro_pkg::sro_qstat_type                    qstat,
   output logic                                      q_push,
   output sro_pkg::sro_seg_type                      q_entry
);

   logic [sro_pkg::SCALE_BITS-1:0]              scale_ff;
   logic [sro_pkg::SIZE_BITS-1:0]               width_ff;
   logic [sro_pkg::SIZE_BITS-1:0]               height_ff;
   logic                                        s1_valid_ff, s1_valid_in;
   logic signed [sro_pkg::PROD_BITS-1:0]        sx_ff, sy_ff, ex_ff, ey_ff;
   logic signed [sro_pkg::PROD_BITS-1:0]        sx_in, sy_in, ex_in, ey_in;
   logic [sro_pkg::HALF_BITS-1:0]               w2_ff, h2_ff;
   logic [sro_pkg::MULW_BITS-1:0]               wfull, hfull;
   logic signed [sro_pkg::PROD_BITS-1:0]        kmul;
   logic [sro_pkg::QCNT_BITS:0]                 committed;
   logic                                        accept;
   logic [sro_pkg::DIR_BITS-1:0]                dir;

   // An item is taken only when the queue is sure to have room for it.
   assign committed = {1'b0, qstat.level} + (sro_pkg::QCNT_BITS + 1)'(s1_valid_ff);
   assign req_full  = committed >= (sro_pkg::QCNT_BITS + 1)'(sro_pkg::QUEUE_DEPTH);
   assign accept    = req_push & ~req_full;
   assign s1_valid_in = accept;

   always_comb begin
      kmul  = $signed(sro_pkg::PROD_BITS'(scale_ff));
      sx_in = sro_pkg::PROD_BITS'(req_start_x) * kmul;
      sy_in = sro_pkg::PROD_BITS'(req_start_y) * kmul;
      ex_in = sro_pkg::PROD_BITS'(req_end_x) * kmul;
      ey_in = sro_pkg::PROD_BITS'(req_end_y) * kmul;
      wfull = sro_pkg::MULW_BITS'(width_ff) * sro_pkg::MULW_BITS'(scale_ff);
      hfull = sro_pkg::MULW_BITS'(height_ff) * sro_pkg::MULW_BITS'(scale_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff    <= sro_pkg::SCALE_BITS'(1);
         width_ff    <= '0;
         height_ff   <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (csr_wen) begin
            case (csr_index)
               sro_pkg::CSR_SCALE_FACTOR:    scale_ff  <= csr_wdata[sro_pkg::SCALE_BITS-1:0];
               sro_pkg::CSR_APERTURE_WIDTH:  width_ff  <= csr_wdata[sro_pkg::SIZE_BITS-1:0];
               sro_pkg::CSR_APERTURE_HEIGHT: height_ff <= csr_wdata[sro_pkg::SIZE_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sx_ff <= sx_in;
         sy_ff <= sy_in;
         ex_ff <= ex_in;
         ey_ff <= ey_in;
         w2_ff <= wfull[sro_pkg::MULW_BITS-1:1];
         h2_ff <= hfull[sro_pkg::MULW_BITS-1:1];
      end
   end

   always_comb begin
      if (ex_ff > sx_ff) begin
         dir = (ey_ff > sy_ff) ? sro_pkg::DIR_XP_YP :
               (sy_ff > ey_ff) ? sro_pkg::DIR_XP_YN : sro_pkg::DIR_XP_Y0;
      end else if (sx_ff > ex_ff) begin
         dir = (ey_ff > sy_ff) ? sro_pkg::DIR_XN_YP :
               (sy_ff > ey_ff) ? sro_pkg::DIR_XN_YN : sro_pkg::DIR_XN_Y0;
      end else begin
         dir = (ey_ff > sy_ff) ? sro_pkg::DIR_X0_YP : sro_pkg::DIR_X0_YN;
      end
   end

   assign q_push      = s1_valid_ff;
   assign q_entry.sx  = sx_ff;
   assign q_entry.sy  = sy_ff;
   assign q_entry.ex  = ex_ff;
   assign q_entry.ey  = ey_ff;
   assign q_entry.w2  = w2_ff;
   assign q_entry.h2  = h2_ff;
   assign q_entry.dir = dir;

endmodule

// File: design/sro_queue.sv
module sro_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_push,
   input  sro_pkg::sro_seg_type   q_entry,
   input  logic                   q_pop,
   output sro_pkg::sro_seg_type   q_head,
   output sro_pkg::sro_qstat_type qstat
);

   sro_pkg::sro_seg_type                mem_ff [sro_pkg::QUEUE_DEPTH];
   logic [sro_pkg::QPTR_BITS-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [sro_pkg::QCNT_BITS-1:0]       level_ff, level_in;

   always_comb begin
      level_in = level_ff;
      if (q_push && !q_pop) begin
         level_in = level_ff + 1'b1;
      end else if (q_pop && !q_push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         level_ff <= level_in;
         if (q_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (q_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         mem_ff[wr_ptr_ff] <= q_entry;
      end
   end

   assign q_head      = mem_ff[rd_ptr_ff];
   assign qstat.empty = (level_ff == '0);
   assign qstat.level = level_ff;

endmodule

// File: design/sro_back.sv
module sro_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  sro_pkg::sro_seg_type                  q_head,
   input  sro_pkg::sro_qstat_type                qstat,
   output logic                                  q_pop,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic signed [sro_pkg::OUT_BITS-1:0]   rsp_vertex_x,
   output logic signed [sro_pkg::OUT_BITS-1:0]   rsp_vertex_y,
   output logic                                  rsp_path_start,
   output logic                                  rsp_last_vertex
);

   logic                                  rsp_valid_ff;
   logic [sro_pkg::STEP_BITS-1:0]         step_ff;
   logic signed [sro_pkg::OUT_BITS-1:0]   vx_ff, vy_ff, vx_in, vy_in;
   logic                                  start_ff, last_ff;
   logic                                  advance, is_last;
   logic [2:0]                            code;
   logic signed [sro_pkg::PROD_BITS-1:0]  px, py;
   logic signed [sro_pkg::SUM_BITS-1:0]   sum_x, sum_y, w2_ext, h2_ext;

   assign advance = ~qstat.empty & (~rsp_valid_ff | rsp_pop);
   assign code    = sro_pkg::ORDER_TAB[q_head.dir][step_ff];
   assign is_last = (step_ff == sro_pkg::ORDER_LAST[q_head.dir]);
   assign q_pop   = advance & is_last;

   always_comb begin
      px     = code[sro_pkg::CODE_END_BIT] ? q_head.ex : q_head.sx;
      py     = code[sro_pkg::CODE_END_BIT] ? q_head.ey : q_head.sy;
      w2_ext = $signed(sro_pkg::SUM_BITS'(q_head.w2));
      h2_ext = $signed(sro_pkg::SUM_BITS'(q_head.h2));
      sum_x  = code[sro_pkg::CODE_WPLUS_BIT] ? sro_pkg::SUM_BITS'(px) + w2_ext
                                              : sro_pkg::SUM_BITS'(px) - w2_ext;
      sum_y  = code[sro_pkg::CODE_HPLUS_BIT] ? sro_pkg::SUM_BITS'(py) + h2_ext
                                              : sro_pkg::SUM_BITS'(py) - h2_ext;
      vx_in  = sro_pkg::sro_sat(sum_x);
      vy_in  = sro_pkg::sro_sat(sum_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            step_ff      <= is_last ? '0 : step_ff + 1'b1;
         end else if (rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         vx_ff    <= vx_in;
         vy_ff    <= vy_in;
         start_ff <= (step_ff == '0);
         last_ff  <= is_last;
      end
   end

   assign rsp_empty       = ~rsp_valid_ff;
   assign rsp_vertex_x    = vx_ff;
   assign rsp_vertex_y    = vy_ff;
   assign rsp_path_start  = start_ff;
   assign rsp_last_vertex = last_ff;

`ifndef ASSERT_OFF
   a_mid_outline_head_held: assert property (@(posedge clock) disable iff (reset)
      (step_ff != '0) |-> !qstat.empty)
      else $error("Queue head left in the middle of an outline.");

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      !qstat.empty |-> (step_ff <= sro_pkg::ORDER_LAST[q_head.dir]))
      else $error("Vertex step runs past the end of the outline.");

   a_start_not_last: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid_ff && start_ff && last_ff))
      else $error("A vertex is flagged both as path start and as last.");

   a_pop_restarts: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (step_ff == '0))
      else $error("Step counter did not restart after an outline.");
`endif

endmodule

// File: design/swept_rectangle_outline_core.sv
// Channel  Ports                          Handshake            Beat
// request  req_start_x .. req_end_y       req_push / req_full   one segment
// result   rsp_vertex_x .. rsp_last_vertex rsp_pop / rsp_empty  one outline vertex
// config   csr_index, csr_wdata           csr_wen              one register write
//
// A segment gives six vertices when diagonal and four otherwise, one vertex per cycle
// while the queue holds a segment and each vertex is popped; the result register sets
// the rate. A vertex passes the front register, the queue and the result register.
// Reset is synchronous; registers return to scale one and a zero aperture.
// A four-entry queue between front and back lets either side stall on its own.
module swept_rectangle_outline_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wen,
   input  logic [sro_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [sro_pkg::CSR_BITS-1:0]          csr_wdata,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic signed [sro_pkg::COORD_BITS-1:0] req_start_x,
   input  logic signed [sro_pkg::COORD_BITS-1:0] req_start_y,
   input  logic signed [sro_pkg::COORD_BITS-1:0] req_end_x,
   input  logic signed [sro_pkg::COORD_BITS-1:0] req_end_y,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic signed [sro_pkg::OUT_BITS-1:0]   rsp_vertex_x,
   output logic signed [sro_pkg::OUT_BITS-1:0]   rsp_vertex_y,
   output logic                                  rsp_path_start,
   output logic                                  rsp_last_vertex
);

   sro_pkg::sro_seg_type   q_entry, q_head;
   sro_pkg::sro_qstat_type qstat;
   logic                   q_push, q_pop;

   sro_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wen     (csr_wen),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_start_x (req_start_x),
      .req_start_y (req_start_y),
      .req_end_x   (req_end_x),
      .req_end_y   (req_end_y),
      .qstat       (qstat),
      .q_push      (q_push),
      .q_entry     (q_entry)
   );

   sro_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_entry (q_entry),
      .q_pop   (q_pop),
      .q_head  (q_head),
      .qstat   (qstat)
   );

   sro_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_head          (q_head),
      .qstat           (qstat),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_vertex_x    (rsp_vertex_x),
      .rsp_vertex_y    (rsp_vertex_y),
      .rsp_path_start  (rsp_path_start),
      .rsp_last_vertex (rsp_last_vertex)
   );

endmodule
